/* rtl/osrs_pkg.sv */
// Shared types and constants for the ordered set range sum unit.
package osrs_pkg;

  localparam int unsigned OSRS_CAPACITY_DEF = 256;
  localparam int unsigned OSRS_KEY_BITS_DEF = 30;

  localparam int unsigned KEY_IN_W = 30;
  localparam int unsigned TOTAL_W  = 38;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_TEST   = 2'd2,
    OP_RANGE  = 2'd3
  } osrs_op_e;

  typedef struct packed {
    osrs_op_e            op;
    logic [KEY_IN_W-1:0] key;
    logic [KEY_IN_W-1:0] range_high;
  } osrs_req_t;

  typedef struct packed {
    logic               found;
    logic [TOTAL_W-1:0] total;
    logic               status;
  } osrs_rsp_t;

endpackage

/* rtl/osrs_engine.sv */
// Table memory with clearing pass, scan sequencer and write-back.
module osrs_engine
  import osrs_pkg::*;
#(
  parameter int unsigned CAPACITY = OSRS_CAPACITY_DEF,
  parameter int unsigned KEY_BITS = OSRS_KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  osrs_req_t req_i,
  output logic      idle_o,
  output logic      done_o,
  input  logic      take_i,
  output osrs_rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } osrs_state_e;

  // Entry word: valid bit above the key.
  logic [KEY_BITS:0] mem [CAPACITY];
  logic [KEY_BITS:0] rdata_q;

  osrs_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;

  osrs_op_e      op_q;
  logic [KEY_BITS-1:0] lo_q, hi_q;

  logic          match_q, match_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  osrs_rsp_t     rsp_q, rsp_d;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [KEY_BITS:0] wdata;

  logic [KEY_IN_W+KEY_BITS-1:0] key_ext, hi_ext;
  logic                e_valid;
  logic [KEY_BITS-1:0] e_key;

  assign key_ext = {{KEY_BITS{1'b0}}, req_i.key};
  assign hi_ext  = {{KEY_BITS{1'b0}}, req_i.range_high};
  assign e_valid = rdata_q[KEY_BITS];
  assign e_key   = rdata_q[KEY_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q  <= mem[cnt_q];
    rd_idx_q <= cnt_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    total_d     = total_q;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = '0;

    // Fold in the entry read in the previous cycle.
    if (rd_vld_q) begin
      if (e_valid && (e_key == lo_q) && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = rd_idx_q;
      end
      if (!e_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
      if ((op_q == OP_RANGE) && e_valid && (e_key >= lo_q) && (e_key <= hi_q)) begin
        total_d = total_q + TOTAL_W'(e_key);
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          match_d = 1'b0;
          free_d  = 1'b0;
          total_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        rsp_d = '0;
        unique case (op_q)
          OP_INSERT: begin
            if (!match_q) begin
              if (free_q) begin
                we    = 1'b1;
                waddr = free_idx_q;
                wdata = {1'b1, lo_q};
              end else begin
                rsp_d.status = 1'b1;
              end
            end
          end
          OP_ERASE: begin
            if (match_q) begin
              we    = 1'b1;
              waddr = match_idx_q;
              wdata = '0;
            end
          end
          OP_TEST:  rsp_d.found = match_q;
          OP_RANGE: rsp_d.total = total_q;
          default:  rsp_d = '0;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      match_q  <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      match_q  <= match_d;
      free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    total_q     <= total_d;
    rsp_q       <= rsp_d;
    if (state_q == ST_IDLE && start_i) begin
      op_q <= req_i.op;
      lo_q <= key_ext[KEY_BITS-1:0];
      hi_q <= hi_ext[KEY_BITS-1:0];
    end
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign rsp_o  = rsp_q;

endmodule

/* rtl/ordered_set_range_sum_unit.sv */
// Top level of the ordered set range sum unit: handshakes and result register.
//
// Usage: a transfer on the input channel carries an operation (insert, erase,
// membership test, range sum), a key and an upper range bound. Each input
// transfer gives exactly one result transfer with found, range_total and status.
// The set lives in one synchronous memory of CAPACITY entries, each a valid
// bit and a key. Every item is a full scan of that memory, one entry a cycle,
// followed by at most one write-back; the scan through the single memory port
// sets when the result is valid and when the next input is taken. One item is
// in work at a time; in_stall_o is high while it runs and while its result
// waits. The result sits in an output register. While the receiver stalls,
// the result is held there and the next item may already be taken and
// scanned; its result then waits in the engine until the register frees.
// After reset a clearing pass writes every entry invalid; in_stall_o stays
// high until it ends.
module ordered_set_range_sum_unit
  import osrs_pkg::*;
#(
  parameter int unsigned CAPACITY = OSRS_CAPACITY_DEF,
  parameter int unsigned KEY_BITS = OSRS_KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [KEY_IN_W-1:0] range_high_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic [TOTAL_W-1:0]  range_total_o,
  output logic                status_o
);

  osrs_req_t req;
  osrs_rsp_t eng_rsp;
  osrs_rsp_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      eng_idle, eng_done, take;

  assign req.op         = osrs_op_e'(operation_i);
  assign req.key        = key_i;
  assign req.range_high = range_high_i;

  // Move the result across when the output register is empty or draining.
  assign take = eng_done && (!out_valid_q || !out_stall_i);

  osrs_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_valid_i),
    .req_i   (req),
    .idle_o  (eng_idle),
    .done_o  (eng_done),
    .take_i  (take),
    .rsp_o   (eng_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= eng_rsp;
    end
  end

  assign in_stall_o    = !eng_idle;
  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign range_total_o = out_q.total;
  assign status_o      = out_q.status;

endmodule
